// ===== hw/rtl/stdp_pkg.sv =====
`timescale 1ns / 1ps

package stdp_pkg;

    // Field and datapath widths
    localparam int unsigned WEIGHT_W = 32;
    localparam int unsigned SPIKE_W  = 64;
    localparam int unsigned STEP_W   = 7;
    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned RATIO_W  = 18;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Shared multiplier: A takes power, ratio-free term; B takes gain, ratio, count
    localparam int unsigned TERM_W  = 26;             // Q10.16 term, floor(gain*P/2^16)
    localparam int unsigned MUL_A_W = TERM_W;
    localparam int unsigned MUL_B_W = GAIN_W;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int unsigned PAIR_W  = 32;             // term times pair count
    localparam int unsigned DELTA_W = 41;             // signed sum over all lags
    localparam int unsigned SUM_W   = DELTA_W + 1;

    localparam logic [RATIO_W-1:0] POW_ONE = 18'h10000;
    localparam logic [RATIO_W-1:0] POW_MAX = 18'h3FFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_P = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_N  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_N = 3'd4;

    localparam logic [STEP_W-1:0]  STEPS_RESET = 7'd64;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd32768;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight_in;
        logic [SPIKE_W-1:0]         pre_spikes;
        logic [SPIKE_W-1:0]         post_spikes;
        logic                       first_sample;
        logic                       last_sample;
    } t_stdp_in;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight_out;
        logic                       saturated;
    } t_stdp_out;

    // Sequencer: per lag, term / power / pair product for each direction
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM_P,
        ST_POW_P,
        ST_CNT_P,
        ST_TERM_N,
        ST_POW_N,
        ST_CNT_N,
        ST_DRAIN,
        ST_SUM
    } t_state;

endpackage

// ===== hw/rtl/stdp_weight_update.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                                   Payload
// in        sink       i_in_valid / o_in_ready                   i_in_data   (t_stdp_in)
// out       source     o_out_valid / i_out_ready                 o_out_data  (t_stdp_out)
// cfg       sink       i_cfg_valid / o_cfg_ready                 i_cfg_index, i_cfg_data
//
// The block takes a new item only once it is done with the last one; its pace is set by
// the single 26x24 multiplier, used three times per lag and direction: term, next power,
// term times pair count.
// Reset is synchronous, active low; it restores register defaults and clears the weight.
// A pending result holds in the output register; the block only stalls at the final
// weight update if the previous result has not been transferred yet.
module stdp_weight_update #(
    parameter int unsigned MAX_STEPS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  stdp_pkg::t_stdp_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output stdp_pkg::t_stdp_out                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stdp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stdp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import stdp_pkg::*;

    localparam int unsigned LAG_W = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;
    localparam int unsigned CNT_W = LAG_W;

    // Configuration registers
    logic [STEP_W-1:0]  r_steps;
    logic [GAIN_W-1:0]  r_gain_p;
    logic [RATIO_W-1:0] r_ratio_p;
    logic [GAIN_W-1:0]  r_gain_n;
    logic [RATIO_W-1:0] r_ratio_n;

    // Sequencer and datapath
    t_state r_state, n_state;
    logic [LAG_W-1:0]     r_lag;
    logic [LAG_W-1:0]     r_last_lag;
    logic [MAX_STEPS-1:0] r_pre, r_post, r_pre_sh, r_post_sh;
    logic [CNT_W-1:0]     r_cnt_p, r_cnt_n;
    logic [RATIO_W-1:0]   r_pow_p, r_pow_n;
    logic [TERM_W-1:0]    r_term;
    logic [MUL_P_W-1:0]   r_prod;
    logic signed [DELTA_W-1:0]  r_delta;
    logic signed [WEIGHT_W-1:0] r_weight_in;
    logic r_first, r_last;
    logic signed [WEIGHT_W-1:0] r_acc;
    logic r_clip_seen;
    logic r_out_valid;
    t_stdp_out r_out_data;

    logic in_fire, sum_go, loop_end;
    logic [STEP_W-1:0]    steps_eff;
    logic [MAX_STEPS-1:0] mask;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic [RATIO_W-1:0]   pow_next;
    logic signed [SUM_W-1:0]    sum;
    logic signed [WEIGHT_W-1:0] sum_sat;
    logic sum_clip;

    function automatic logic [CNT_W-1:0] popcnt(input logic [MAX_STEPS-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < int'(MAX_STEPS); i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

    // Step count clamp and active-step mask
    always_comb begin
        if (r_steps == '0) begin
            steps_eff = STEP_W'(1);
        end else if (r_steps > STEP_W'(MAX_STEPS)) begin
            steps_eff = STEP_W'(MAX_STEPS);
        end else begin
            steps_eff = r_steps;
        end
        for (int i = 0; i < int'(MAX_STEPS); i++) begin
            mask[i] = (STEP_W'(i) < steps_eff);
        end
    end

    assign in_fire  = i_in_valid && o_in_ready;
    assign loop_end = (r_lag == r_last_lag);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (steps_eff == STEP_W'(1)) ? ST_SUM : ST_TERM_P;
                end
            end
            ST_TERM_P: n_state = ST_POW_P;
            ST_POW_P:  n_state = ST_CNT_P;
            ST_CNT_P:  n_state = ST_TERM_N;
            ST_TERM_N: n_state = ST_POW_N;
            ST_POW_N:  n_state = ST_CNT_N;
            ST_CNT_N:  n_state = loop_end ? ST_DRAIN : ST_TERM_P;
            ST_DRAIN:  n_state = ST_SUM;
            ST_SUM: begin
                if (sum_go) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshakes and multiplier operand select
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        sum_go     = (r_state == ST_SUM) && (!r_last || !r_out_valid || i_out_ready);
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            ST_TERM_P: begin
                mul_a = MUL_A_W'(r_pow_p);
                mul_b = r_gain_p;
            end
            ST_POW_P: begin
                mul_a = MUL_A_W'(r_pow_p);
                mul_b = MUL_B_W'(r_ratio_p);
            end
            ST_CNT_P: begin
                mul_a = r_term;
                mul_b = MUL_B_W'(r_cnt_p);
            end
            ST_TERM_N: begin
                mul_a = MUL_A_W'(r_pow_n);
                mul_b = r_gain_n;
            end
            ST_POW_N: begin
                mul_a = MUL_A_W'(r_pow_n);
                mul_b = MUL_B_W'(r_ratio_n);
            end
            ST_CNT_N: begin
                mul_a = r_term;
                mul_b = MUL_B_W'(r_cnt_n);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // Shared multiplier and power clamp of the previous product
    assign mul_p    = mul_a * mul_b;
    assign pow_next = (r_prod[35:34] != 2'b00) ? POW_MAX : r_prod[33:16];

    // Final weight: base plus delta, saturated to 32 bits
    always_comb begin
        sum = (r_first ? SUM_W'(r_weight_in) : SUM_W'(r_acc)) + SUM_W'(r_delta);
        if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
            sum_sat  = 32'sh7FFF_FFFF;
            sum_clip = 1'b1;
        end else if (sum < -SUM_W'(64'sh8000_0000)) begin
            sum_sat  = 32'sh8000_0000;
            sum_clip = 1'b1;
        end else begin
            sum_sat  = sum[WEIGHT_W-1:0];
            sum_clip = 1'b0;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_steps     <= STEPS_RESET;
            r_gain_p    <= '0;
            r_ratio_p   <= RATIO_RESET;
            r_gain_n    <= '0;
            r_ratio_n   <= RATIO_RESET;
            r_acc       <= '0;
            r_clip_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEPS:   r_steps   <= i_cfg_data[STEP_W-1:0];
                    CFG_GAIN_P:  r_gain_p  <= i_cfg_data[GAIN_W-1:0];
                    CFG_RATIO_P: r_ratio_p <= i_cfg_data[RATIO_W-1:0];
                    CFG_GAIN_N:  r_gain_n  <= i_cfg_data[GAIN_W-1:0];
                    CFG_RATIO_N: r_ratio_n <= i_cfg_data[RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (sum_go) begin
                r_acc       <= sum_sat;
                r_clip_seen <= (r_first ? 1'b0 : r_clip_seen) | sum_clip;
            end
            if (sum_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_pre       <= i_in_data.pre_spikes[MAX_STEPS-1:0] & mask;
                    r_post      <= i_in_data.post_spikes[MAX_STEPS-1:0] & mask;
                    r_pre_sh    <= (i_in_data.pre_spikes[MAX_STEPS-1:0] & mask) << 1;
                    r_post_sh   <= (i_in_data.post_spikes[MAX_STEPS-1:0] & mask) << 1;
                    r_weight_in <= i_in_data.weight_in;
                    r_first     <= i_in_data.first_sample;
                    r_last      <= i_in_data.last_sample;
                    r_lag       <= LAG_W'(1);
                    r_last_lag  <= LAG_W'(steps_eff - STEP_W'(1));
                    r_pow_p     <= POW_ONE;
                    r_pow_n     <= POW_ONE;
                    r_delta     <= '0;
                end
            end
            ST_TERM_P: begin
                // pair counts for this lag; retire the depression product of the last lag
                r_cnt_p <= popcnt(r_post & r_pre_sh);
                r_cnt_n <= popcnt(r_pre & r_post_sh);
                if (r_lag != LAG_W'(1)) begin
                    r_delta <= r_delta - DELTA_W'(r_prod[PAIR_W-1:0]);
                end
            end
            ST_POW_P:  r_term  <= r_prod[TERM_W+15:16];
            ST_CNT_P:  r_pow_p <= pow_next;
            ST_TERM_N: r_delta <= r_delta + DELTA_W'(r_prod[PAIR_W-1:0]);
            ST_POW_N:  r_term  <= r_prod[TERM_W+15:16];
            ST_CNT_N: begin
                r_pow_n   <= pow_next;
                r_pre_sh  <= r_pre_sh << 1;
                r_post_sh <= r_post_sh << 1;
                if (!loop_end) begin
                    r_lag <= r_lag + LAG_W'(1);
                end
            end
            ST_DRAIN:  r_delta <= r_delta - DELTA_W'(r_prod[PAIR_W-1:0]);
            default: ;
        endcase
        if (sum_go && r_last) begin
            r_out_data.weight_out <= sum_sat;
            r_out_data.saturated  <= (r_first ? 1'b0 : r_clip_seen) | sum_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after an input transfer");

    a_lag_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CNT_N) |-> (r_lag <= r_last_lag))
        else $error("lag counter ran past the last lag");

    a_result_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_SUM) && $past(r_last))
        else $error("result raised outside the final update of a last sample");

endmodule

// ===== tb/sv/stdp_weight_checker.sv =====
`timescale 1ns / 1ps

module stdp_weight_checker #(
    parameter int unsigned MAX_STEPS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  stdp_pkg::t_stdp_in              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  stdp_pkg::t_stdp_out             i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [stdp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stdp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_weights_checked,
    output int                              o_clipped_weights
);
    import stdp_pkg::*;

    localparam longint WEIGHT_MAX = 64'sd2147483647;
    localparam longint WEIGHT_MIN = -64'sd2147483647 - 64'sd1;

    // Shadow copy of the block's registers and synapse state
    logic [STEP_W-1:0]          steps_reg;
    logic [GAIN_W-1:0]          gain_pot;
    logic [RATIO_W-1:0]         ratio_pot;
    logic [GAIN_W-1:0]          gain_dep;
    logic [RATIO_W-1:0]         ratio_dep;
    logic signed [WEIGHT_W-1:0] acc_weight;
    logic                       clip_flag;

    t_stdp_out expected_weights[$];
    int        fails;
    int        checked;
    int        clipped;

    // Decay power for the next lag, Q2.16, clamped at its top code
    function automatic longint next_power(input longint p, input logic [RATIO_W-1:0] ratio);
        longint q;
        q = (p * longint'(ratio)) >> 16;
        return (q > longint'(POW_MAX)) ? longint'(POW_MAX) : q;
    endfunction

    // STDP update of one sample; queues the emitted weight on a last sample
    function automatic void apply_sample(input t_stdp_in s);
        int unsigned     steps;
        int unsigned     d;
        logic [63:0]     mask;
        logic [63:0]     pre;
        logic [63:0]     post;
        longint          pow_p;
        longint          pow_n;
        longint          term_p;
        longint          term_n;
        longint          delta;
        longint          total;
        t_stdp_out       res;
        steps = 32'(steps_reg);
        if (steps < 1) steps = 1;
        if (steps > MAX_STEPS) steps = MAX_STEPS;
        mask = (steps >= 64) ? {64{1'b1}} : ((64'd1 << steps) - 64'd1);
        pre = s.pre_spikes & mask;
        post = s.post_spikes & mask;
        pow_p = longint'(POW_ONE);
        pow_n = longint'(POW_ONE);
        delta = 0;
        for (d = 1; d < steps; d++) begin
            term_p = (longint'(gain_pot) * pow_p) >> 16;
            term_n = (longint'(gain_dep) * pow_n) >> 16;
            delta += term_p * longint'($countones(post & (pre << d) & mask));
            delta -= term_n * longint'($countones(pre & (post << d) & mask));
            pow_p = next_power(pow_p, ratio_pot);
            pow_n = next_power(pow_n, ratio_dep);
        end
        if (s.first_sample) begin
            total = longint'($signed(s.weight_in));
            clip_flag = 1'b0;
        end else begin
            total = longint'(acc_weight);
        end
        total += delta;
        if (total > WEIGHT_MAX) begin
            total = WEIGHT_MAX;
            clip_flag = 1'b1;
        end else if (total < WEIGHT_MIN) begin
            total = WEIGHT_MIN;
            clip_flag = 1'b1;
        end
        acc_weight = total[WEIGHT_W-1:0];
        if (s.last_sample) begin
            res.weight_out = acc_weight;
            res.saturated = clip_flag;
            expected_weights.push_back(res);
        end
    endfunction

    // Watch all three channels; results are checked before the new sample is taken in
    always @(posedge i_clk) begin : watch
        t_stdp_out want;
        if (!i_rst_n) begin
            steps_reg = STEPS_RESET;
            gain_pot = '0;
            ratio_pot = RATIO_RESET;
            gain_dep = '0;
            ratio_dep = RATIO_RESET;
            acc_weight = '0;
            clip_flag = 1'b0;
            expected_weights.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEPS:   steps_reg = i_cfg_data[STEP_W-1:0];
                    CFG_GAIN_P:  gain_pot = i_cfg_data[GAIN_W-1:0];
                    CFG_RATIO_P: ratio_pot = i_cfg_data[RATIO_W-1:0];
                    CFG_GAIN_N:  gain_dep = i_cfg_data[GAIN_W-1:0];
                    CFG_RATIO_N: ratio_dep = i_cfg_data[RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_weights.size() == 0) begin
                    $error("unexpected weight transfer: weight_out %0d saturated %0b",
                           i_out_data.weight_out, i_out_data.saturated);
                    fails++;
                end else begin
                    want = expected_weights.pop_front();
                    checked++;
                    if (want.saturated) clipped++;
                    if (i_out_data.weight_out !== want.weight_out) begin
                        $error("weight_out: expected %0d, got %0d",
                               want.weight_out, i_out_data.weight_out);
                        fails++;
                    end
                    if (i_out_data.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, i_out_data.saturated);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) apply_sample(i_in_data);
        end
        o_fail_count <= fails;
        o_pending <= expected_weights.size();
        o_weights_checked <= checked;
        o_clipped_weights <= clipped;
    end

endmodule

// ===== tb/sv/tb_stdp_weight_update.sv =====
`timescale 1ns / 1ps

module tb_stdp_weight_update;
    import stdp_pkg::*;

    localparam int unsigned MAX_STEPS = 64;
    localparam int CLK_HALF = 5;
    // worst item is at the largest step count; margin on top
    localparam int SETTLE_CYCLES = 6 * MAX_STEPS + 16;
    localparam int LONG_HOLD = 3000;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_stdp_in              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_stdp_out             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_STEPS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int weights_checked;
    int clipped_weights;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit offering = 1'b0;
    bit hold_request = 1'b0;
    bit hold_served = 1'b0;
    int samples_sent = 0;
    int settings_applied = 0;
    int run_len = 0;
    int run_left = 0;
    bit run_noisy = 1'b0;

    stdp_weight_update #(
        .MAX_STEPS(MAX_STEPS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    stdp_weight_checker #(
        .MAX_STEPS(MAX_STEPS)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_in_data         (in_data),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_out_data        (out_data),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_weights_checked (weights_checked),
        .o_clipped_weights (clipped_weights)
    );

    // 100 MHz clock
    always begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // Result side: random stalls, plus one long hold-off when requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request && !hold_served) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_stdp_in spike_sample(input logic [31:0] w, input logic [63:0] pre,
                                              input logic [63:0] post, input logic first,
                                              input logic last);
        t_stdp_in s;
        s.weight_in = w;
        s.pre_spikes = pre;
        s.post_spikes = post;
        s.first_sample = first;
        s.last_sample = last;
        return s;
    endfunction

    function automatic logic [31:0] any_weight();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] any_spikes();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(7))
            0: r = '0;
            1: r = '1;
            2: r = 64'd1 << $urandom_range(0, 63);
            3, 4: r = r & {$urandom, $urandom} & {$urandom, $urandom};
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        logic [GAIN_W-1:0] g;
        g = GAIN_W'($urandom);
        return g >> $urandom_range(0, 16);
    endfunction

    function automatic logic [RATIO_W-1:0] rand_ratio();
        case ($urandom_range(3))
            0: return RATIO_W'($urandom_range(0, 18'h3FFFF));
            1: return RATIO_W'($urandom_range(18'h08000, 18'h10000));
            default: return RATIO_W'($urandom_range(18'h0C000, 18'h14000));
        endcase
    endfunction

    // One sample transfer, with an optional random gap in front
    task automatic send_sample(input t_stdp_in s);
        if ($urandom_range(99) < send_idle_pct) begin
            if (offering) in_valid <= 1'b0;
            offering = 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= s;
        offering = 1'b1;
        do @(posedge clk); while (!in_ready);
        samples_sent++;
    endtask

    // Wait until every queued weight has come out
    task automatic drain();
        if (offering) in_valid <= 1'b0;
        offering = 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic drain_settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers back to back; block must be idle
    task automatic configure(input logic [STEP_W-1:0] steps, input logic [GAIN_W-1:0] g_p,
                             input logic [RATIO_W-1:0] r_p, input logic [GAIN_W-1:0] g_n,
                             input logic [RATIO_W-1:0] r_n);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        int i;
        idx = '{CFG_STEPS, CFG_GAIN_P, CFG_RATIO_P, CFG_GAIN_N, CFG_RATIO_N};
        val[0] = CFG_DATA_W'(steps);
        val[1] = g_p;
        val[2] = CFG_DATA_W'(r_p);
        val[3] = g_n;
        val[4] = CFG_DATA_W'(r_n);
        for (i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Mostly well-formed first..last runs, some with random flags
    task automatic random_phase(input int n, input int snd, input int rcv,
                                input logic [STEP_W-1:0] steps, input bit with_hold);
        logic first;
        logic last;
        int k;
        configure(steps, rand_gain(), rand_ratio(), rand_gain(), rand_ratio());
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        if (with_hold) hold_request = 1'b1;
        for (k = 0; k < n; k++) begin
            if (run_left == 0) begin
                run_len = $urandom_range(1, 6);
                run_left = run_len;
                run_noisy = ($urandom_range(99) < 15);
            end
            first = (run_left == run_len);
            last = (run_left == 1);
            if (run_noisy) begin
                first = 1'($urandom);
                last = 1'($urandom);
            end
            run_left--;
            send_sample(spike_sample(any_weight(), any_spikes(), any_spikes(), first, last));
            // occasional full pause until all weights are out
            if ($urandom_range(99) < 3) drain();
        end
        drain_settle();
    endtask

    // Stimulus
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: zero gains
        send_sample(spike_sample(32'h0001_2345, '1, '1, 1'b1, 1'b1));
        drain_settle();

        configure(7'd64, 24'h01_0000, 18'h0_8000, 24'h00_8000, 18'h0_C000);
        send_sample(spike_sample(32'h0, 64'h1, 64'h2, 1'b1, 1'b1));
        send_sample(spike_sample(32'h0, 64'h2, 64'h1, 1'b1, 1'b1));
        // equal-step pairs plus the longest lag both ways
        send_sample(spike_sample(32'h0005_0000, 64'h8000_0000_0000_0001,
                                 64'h8000_0000_0000_0001, 1'b1, 1'b1));
        // clip at both ends
        send_sample(spike_sample(32'h7FFF_FFFF, 64'h1, '1, 1'b1, 1'b1));
        send_sample(spike_sample(32'h8000_0000, '1, 64'h1, 1'b1, 1'b1));
        send_sample(spike_sample(32'h0, '0, '0, 1'b1, 1'b1));
        // multi-sample run, then a continuation without a first
        send_sample(spike_sample(32'h0010_0000, '1, '1, 1'b1, 1'b0));
        send_sample(spike_sample(32'h0BAD_F00D, 64'hAAAA_AAAA_AAAA_AAAA,
                                 64'h5555_5555_5555_5555, 1'b0, 1'b0));
        send_sample(spike_sample(32'h0, 64'h0F0F_0F0F_0F0F_0F0F,
                                 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, 1'b1));
        send_sample(spike_sample(32'hFFFF_FFFF, 64'h3, 64'hC, 1'b0, 1'b1));
        // clip flag sticks through the run and is cleared by the next first
        send_sample(spike_sample(32'h7FFF_0000, 64'h1, '1, 1'b1, 1'b0));
        send_sample(spike_sample(32'h0, '1, 64'h1, 1'b0, 1'b1));
        send_sample(spike_sample(32'h0, '0, '0, 1'b0, 1'b1));
        send_sample(spike_sample(32'h1234_0000, '0, '0, 1'b1, 1'b1));
        drain_settle();

        // zero steps act as one: no lags at all
        configure(7'd0, 24'hFF_FFFF, 18'h3_FFFF, 24'hFF_FFFF, 18'h3_FFFF);
        send_sample(spike_sample(32'h7FFF_FFFF, '1, '1, 1'b1, 1'b1));
        drain_settle();

        // steps above the maximum act as the maximum; power saturates, zero ratio
        configure(7'd127, 24'hFF_FFFF, 18'h3_FFFF, 24'hFF_FFFF, 18'h0_0000);
        send_sample(spike_sample(32'h0, 64'h1, '1, 1'b1, 1'b1));
        send_sample(spike_sample(32'h0, '1, 64'h1, 1'b1, 1'b1));
        drain_settle();

        // spike bits at or above the step count are ignored
        configure(7'd5, 24'h02_0000, 18'h1_0000, 24'h01_8000, 18'h0_0000);
        send_sample(spike_sample(32'h0, 64'hFFFF_FFFF_FFFF_FFE1,
                                 64'hFFFF_FFFF_FFFF_FFE2, 1'b1, 1'b1));
        drain_settle();

        // smallest nonzero gains at two steps
        configure(7'd2, 24'h00_0001, 18'h3_FFFF, 24'h00_0001, 18'h0_0001);
        send_sample(spike_sample(32'h0, 64'h1, 64'h2, 1'b1, 1'b1));
        send_sample(spike_sample(32'h0, 64'h2, 64'h1, 1'b1, 1'b1));
        drain_settle();

        // random runs across idle and stall phases
        random_phase(100, 0, 0, 7'($urandom_range(2, 16)), 1'b0);
        random_phase(100, 82, 0, 7'($urandom_range(2, 16)), 1'b0);
        random_phase(100, 0, 82, 7'($urandom_range(2, 16)), 1'b0);
        random_phase(100, 20, 20, 7'($urandom_range(2, 24)), 1'b0);
        // long receiver hold-off: block fills and stalls its input
        random_phase(60, 0, 0, 7'd3, 1'b1);
        random_phase(40, 20, 20, 7'd64, 1'b0);
        random_phase(100, 82, 82, 7'($urandom_range(1, 12)), 1'b0);
        random_phase(30, 0, 20, 7'd1, 1'b0);
        random_phase(30, 20, 0, 7'd127, 1'b0);
        random_phase(30, 0, 0, 7'd0, 1'b0);

        $display("Summary: %0d samples over %0d register settings, %0d weights compared",
                 samples_sent, settings_applied, weights_checked);
        $display("Summary: %0d of them clipped; steps 0..127 and long backpressure covered",
                 clipped_weights);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #(20_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/stdp_pkg.sv
hw/rtl/stdp_weight_update.sv
tb/sv/stdp_weight_checker.sv
tb/sv/tb_stdp_weight_update.sv
